### rtl/ird_pkg.sv
package ird_pkg;

    // element width carried through the chain
    localparam int DATA_W = 32;

    // capacity after reset
    localparam logic [4:0] CAPACITY_RESET = 5'd16;

    // request codes
    localparam logic [1:0] REQ_INSERT    = 2'd0;
    localparam logic [1:0] REQ_POP_FRONT = 2'd1;
    localparam logic [1:0] REQ_POP_REAR  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // per-cycle command broadcast to every cell
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP_REAR,
        OP_DROP_FRONT,
        OP_FLUSH
    } cell_op_t;

    // what one cell hands to its neighbours
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
    } link_t;

endpackage

### rtl/ird_cell.sv
module ird_cell
    import ird_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cell_op_t op,
    input  link_t    from_rear,
    input  link_t    from_front,
    output link_t    link,
    output logic     tail
);

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // next contents from the broadcast command and the neighbours
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (op)
            OP_PUSH:
            begin
                valid_next = from_rear.valid;
                data_next  = from_rear.data;
            end
            OP_POP_REAR:
            begin
                valid_next = from_front.valid;
                data_next  = from_front.data;
            end
            OP_DROP_FRONT:
            begin
                valid_next = valid_reg & from_front.valid;
            end
            OP_FLUSH:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // element storage
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign link.valid = valid_reg;
    assign link.data  = data_reg;

    // oldest element sits in the last occupied cell
    assign tail = valid_reg & ~from_front.valid;

endmodule

### rtl/input_restricted_deque_unit.sv
// Input-restricted deque: elements enter at the rear only and leave from
// either the front or the rear.
// Request channel: in_valid/in_stall with req_type and in_value. A request
// is taken at a clock edge where in_valid is high and in_stall is low.
// Result channel: out_valid/out_stall with out_value and status; exactly
// one result per request, in request order.
// Results are registered, shown the cycle after the request is taken; one
// request per cycle is sustained unless stalled. Elements live in a row of
// MAX_DEPTH cells shifting together; each request is a single broadcast step.
// in_stall rises only while a result is held and the receiver stalls it;
// the held result and its payload stay put until taken.
// Configuration: cfg_valid/cfg_ready carrying cfg_data (capacity). cfg_ready
// is always high; a write empties the deque. Values of 0 act as 1 and
// values above MAX_DEPTH act as MAX_DEPTH.
// Reset empties the deque, drops any held result and sets capacity to 16
// (or MAX_DEPTH if smaller). No clearing pass is needed after reset.
module input_restricted_deque_unit
    import ird_pkg::*;
#(
    parameter int MAX_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] in_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_value,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data
);

    localparam int IDXW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CAP_RST = (MAX_DEPTH < int'(CAPACITY_RESET)) ?
                             MAX_DEPTH : int'(CAPACITY_RESET);
    localparam logic [IDXW-1:0] CAP_RST_IDX = IDXW'(CAP_RST - 1);

    logic [IDXW-1:0]   cap_idx_reg;
    logic [IDXW-1:0]   cap_idx_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_value_reg;
    logic [DATA_W-1:0] out_value_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;

    cell_op_t          op;
    link_t             cell_link [MAX_DEPTH];
    logic              cell_tail [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] vld_vec;
    logic              accept;
    logic              cfg_write;
    logic              empty;
    logic              full;
    logic [DATA_W-1:0] front_val;

    // handshakes
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;

    // row of cells
    for (genvar i = 0; i < MAX_DEPTH; i++)
    begin : g_cell
        link_t rear_src;
        link_t front_src;

        if (i == 0)
        begin : g_first
            assign rear_src.valid = 1'b1;
            assign rear_src.data  = in_value;
        end
        else
        begin : g_mid_r
            assign rear_src = cell_link[i-1];
        end

        if (i == MAX_DEPTH - 1)
        begin : g_last
            assign front_src.valid = 1'b0;
            assign front_src.data  = '0;
        end
        else
        begin : g_mid_f
            assign front_src = cell_link[i+1];
        end

        ird_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .from_rear  (rear_src),
            .from_front (front_src),
            .link       (cell_link[i]),
            .tail       (cell_tail[i])
        );

        assign vld_vec[i] = cell_link[i].valid;
    end

    // occupancy from the thermometer of valid flags
    assign empty = ~vld_vec[0];
    assign full  = vld_vec[cap_idx_reg];

    // pick the oldest element from whichever cell is the tail
    always_comb
    begin
        front_val = '0;
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            front_val = front_val | (cell_tail[i] ? cell_link[i].data : '0);
        end
    end

    // saturate the written capacity into a cell index
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cap_idx_next = '0;
        end
        else if (32'(cfg_data) > 32'(MAX_DEPTH))
        begin
            cap_idx_next = IDXW'(MAX_DEPTH - 1);
        end
        else
        begin
            cap_idx_next = IDXW'(32'(cfg_data) - 32'd1);
        end
    end

    // request decode: cell command and result
    always_comb
    begin
        op             = OP_HOLD;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        if (cfg_write)
        begin
            op = OP_FLUSH;
        end
        else if (accept)
        begin
            out_value_next = '0;
            status_next    = ST_OK;
            case (req_type)
                REQ_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        op = OP_PUSH;
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        op             = OP_DROP_FRONT;
                        out_value_next = front_val;
                    end
                end
                REQ_POP_REAR:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        op             = OP_POP_REAR;
                        out_value_next = cell_link[0].data;
                    end
                end
                default:
                begin
                    op = OP_HOLD;
                end
            endcase
        end
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cap_idx_reg   <= CAP_RST_IDX;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                cap_idx_reg <= cap_idx_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;

    // occupied cells always form a contiguous run from the rear
    a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
        ((vld_vec >> 1) & ~vld_vec) == '0)
        else $error("occupied cells are not contiguous");

    // never more elements than the capacity allows
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        ((vld_vec >> cap_idx_reg) >> 1) == '0)
        else $error("element count exceeds capacity");

    // an accepted insert lands in the rear cell
    a_insert: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_write && req_type == REQ_INSERT && !full
        |=> vld_vec[0] && cell_link[0].data == $past(in_value) && status == ST_OK)
        else $error("insert did not reach the rear cell");

    // a removal from an empty deque reports empty with zero data
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_write && empty &&
        (req_type == REQ_POP_FRONT || req_type == REQ_POP_REAR)
        |=> out_valid && status == ST_EMPTY && out_value == 0)
        else $error("removal from empty deque not reported");

endmodule

### dv/testbench.sv
module testbench
    import ird_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [4:0] MAX_ELEMS = 5'd16;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } deque_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         req_type;
    logic signed [31:0] in_value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [4:0]         cfg_data;

    // predicted deque state
    logic [31:0] deque_slots [0:16];
    logic [4:0]  head_ptr;
    logic [4:0]  tail_ptr;
    logic [4:0]  deque_capacity;

    deque_result_t expected_results [$];
    int error_count = 0;
    int cycle_count = 0;
    int tx_max = 16;
    int rx_max = 16;
    int rx_hold = 0;
    int stall_left = 0;

    input_restricted_deque_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .in_value  (in_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_value (out_value),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock generation
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ring index helpers
    function automatic logic [4:0] ring_step(logic [4:0] p, logic [4:0] n);
        return (p + 5'd1 >= n) ? 5'd0 : p + 5'd1;
    endfunction

    function automatic logic [4:0] ring_back(logic [4:0] p, logic [4:0] n);
        return (p == 5'd0) ? n - 5'd1 : p - 5'd1;
    endfunction

    // deque behaviour for one accepted request
    function automatic deque_result_t predict_request(logic [1:0] req, logic [31:0] val);
        deque_result_t res;
        logic [4:0] ring_len;
        logic [4:0] nxt;
        res.value = '0;
        res.status = ST_OK;
        if (deque_capacity == 5'd0)
            ring_len = 5'd2;
        else if (deque_capacity > MAX_ELEMS)
            ring_len = MAX_ELEMS + 5'd1;
        else
            ring_len = deque_capacity + 5'd1;
        case (req)
            REQ_INSERT:
            begin
                nxt = ring_step(tail_ptr, ring_len);
                if (nxt == head_ptr)
                    res.status = ST_FULL;
                else
                begin
                    tail_ptr = nxt;
                    deque_slots[nxt] = val;
                end
            end
            REQ_POP_FRONT, REQ_POP_REAR:
            begin
                if (head_ptr == tail_ptr)
                    res.status = ST_EMPTY;
                else if (ring_step(head_ptr, ring_len) == tail_ptr)
                begin
                    // last element leaves from either end
                    res.value = deque_slots[tail_ptr];
                    head_ptr = 5'd0;
                    tail_ptr = 5'd0;
                end
                else if (req == REQ_POP_FRONT)
                begin
                    head_ptr = ring_step(head_ptr, ring_len);
                    res.value = deque_slots[head_ptr];
                end
                else
                begin
                    res.value = deque_slots[tail_ptr];
                    tail_ptr = ring_back(tail_ptr, ring_len);
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // offer one request and record its expected result once taken
    task automatic send_request(logic [1:0] req, logic [31:0] val);
        int gap;
        gap = (tx_max == 0) ? 0 : $urandom_range(tx_max, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        in_value <= val;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(predict_request(req, val));
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // capacity write while idle; empties the deque
    task automatic write_capacity(logic [4:0] cap);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        deque_capacity = cap;
        head_ptr = 5'd0;
        tail_ptr = 5'd0;
    endtask

    // receiver: per-result stall draw, plus a long hold when requested
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rx_hold = rx_hold - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (out_valid && !out_stall)
                    stall_left = (rx_max == 0) ? 0 : $urandom_range(rx_max, 0);
                if (stall_left > 0)
                begin
                    stall_left = stall_left - 1;
                    out_stall <= 1'b1;
                end
                else
                    out_stall <= 1'b0;
            end
        end
    end

    // result checking against the oldest expectation
    always @(posedge clk)
    begin : result_check
        deque_result_t expd;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got value %0d status %0d",
                         $time, out_value, status);
                error_count = error_count + 1;
            end
            else
            begin
                expd = expected_results.pop_front();
                if (out_value !== expd.value)
                begin
                    $display("%0t ns: out_value mismatch, expected %0d, got %0d",
                             $time, expd.value, out_value);
                    error_count = error_count + 1;
                end
                if (status !== expd.status)
                begin
                    $display("%0t ns: status mismatch, expected %0d, got %0d",
                             $time, expd.status, status);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // removals and the unused code on an empty deque
    task automatic test_empty_and_unused();
        send_request(REQ_POP_FRONT, 32'h1234_5678);
        send_request(REQ_POP_REAR, 32'hFFFF_FFFF);
        send_request(REQ_UNUSED, 32'hA5A5_5A5A);
    endtask

    // extreme values in and out of both ends, down to the last element
    task automatic test_extremes_and_last_element();
        send_request(REQ_INSERT, 32'h7FFF_FFFF);
        send_request(REQ_INSERT, 32'h8000_0000);
        send_request(REQ_INSERT, 32'h0000_0000);
        send_request(REQ_INSERT, 32'hFFFF_FFFF);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_UNUSED, 32'h0000_0001);
        send_request(REQ_POP_REAR, 32'h0);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_POP_REAR, 32'h0);
    endtask

    // smallest capacities, refused inserts and single-element removals
    task automatic test_capacity_limits();
        write_capacity(5'd0);
        send_request(REQ_INSERT, 32'h5555_AAAA);
        send_request(REQ_INSERT, 32'hAAAA_5555);
        send_request(REQ_POP_REAR, 32'h0);
        write_capacity(5'd2);
        send_request(REQ_INSERT, 32'h0000_0011);
        send_request(REQ_INSERT, 32'h0000_0022);
        send_request(REQ_INSERT, 32'h0000_0033);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_POP_FRONT, 32'h0);
    endtask

    // one stretch of random traffic at a given capacity and insert bias
    task automatic run_random_phase(logic [4:0] cap, int count, int insert_pct);
        int roll;
        logic [1:0] req;
        logic [31:0] val;
        write_capacity(cap);
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 4)
                req = REQ_UNUSED;
            else if (roll < 4 + (insert_pct * 96) / 100)
                req = REQ_INSERT;
            else
                req = $urandom_range(1, 0) ? REQ_POP_FRONT : REQ_POP_REAR;
            if ($urandom_range(7, 0) == 0)
                val = $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            else
                val = $urandom;
            send_request(req, val);
        end
    endtask

    // random traffic across several capacity settings
    task automatic test_random_traffic();
        run_random_phase(5'd16, 80, 75);
        run_random_phase(5'd16, 40, 20);
        run_random_phase(5'd31, 70, 60);
        run_random_phase(5'd1, 40, 50);
        run_random_phase(5'd0, 20, 50);
        run_random_phase(5'd17, 60, 70);
        run_random_phase(5'd5, 60, 55);
        run_random_phase(5'($urandom_range(31, 0)), 40, 60);
        run_random_phase(5'($urandom_range(31, 0)), 40, 45);
        // back-to-back stretch with no idling on either side
        tx_max = 0;
        rx_max = 0;
        run_random_phase(5'd8, 60, 55);
        tx_max = 16;
        rx_max = 16;
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        write_capacity(5'd16);
        tx_max = 0;
        rx_hold = 60;
        for (int i = 0; i < 20; i++)
            send_request((i % 5 == 4) ? REQ_POP_FRONT : REQ_INSERT, $urandom);
        tx_max = 16;
        drain_results();
        for (int i = 0; i < 10; i++)
            send_request((i % 2 == 0) ? REQ_POP_REAR : REQ_INSERT, $urandom);
    endtask

    // main sequence
    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        req_type <= REQ_INSERT;
        in_value <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        for (int k = 0; k < 17; k++)
            deque_slots[k] = '0;
        head_ptr = 5'd0;
        tail_ptr = 5'd0;
        deque_capacity = CAPACITY_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_unused();
        test_extremes_and_last_element();
        test_capacity_limits();
        test_random_traffic();
        test_backpressure();

        drain_results();
        repeat (5) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
rtl/ird_pkg.sv
rtl/ird_cell.sv
rtl/input_restricted_deque_unit.sv
dv/testbench.sv
